[src/sbda_pkg.sv]
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared types and constants for the signed binary to decimal ASCII unit.
// ----------------------------------------------------------------------------
package sbda_pkg;

    localparam int VALUE_W      = 32;
    localparam int CH_W         = 7;
    localparam int DIGIT_W      = 4;
    localparam int MAX_DIGITS   = 10;
    localparam int COUNT_W      = 4;
    localparam int QUOT_W       = 29;
    localparam int RECIP_SHIFT  = 35;

    // ceil(2^35 / 10); exact floor(x / 10) for every 32-bit x.
    localparam logic [VALUE_W-1:0] C_RECIP_10   = 32'hCCCC_CCCD;
    localparam logic [CH_W-1:0]    C_ASCII_MINUS = 7'd45;
    localparam logic [CH_W-1:0]    C_ASCII_ZERO  = 7'd48;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_DIGIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic pop;
        logic sel_sign;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic quot_zero;
        logic neg;
        logic last_digit;
    } t_sts;

endpackage

[src/sbda_datapath.sv]
// ----------------------------------------------------------------------------
// sbda_datapath
// Magnitude register, divide-by-ten step, digit stack and character output.
// ----------------------------------------------------------------------------
module sbda_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [sbda_pkg::VALUE_W-1:0] i_value,
    input  sbda_pkg::t_cmd                     i_cmd,
    output sbda_pkg::t_sts                     o_sts,
    output logic [sbda_pkg::CH_W-1:0]          o_ch,
    output logic                               o_last
);
    import sbda_pkg::*;

    logic [VALUE_W-1:0]   r_mag;
    logic [VALUE_W-1:0]   n_mag;
    logic                 r_neg;
    logic                 n_neg;
    logic [COUNT_W-1:0]   r_count;
    logic [COUNT_W-1:0]   n_count;
    logic [DIGIT_W-1:0]   r_stack [MAX_DIGITS];

    logic [2*VALUE_W-1:0] prod;
    logic [QUOT_W-1:0]    quot;
    logic [VALUE_W-1:0]   quot_x10;
    logic [VALUE_W-1:0]   rem_full;
    logic [DIGIT_W-1:0]   rem;

    // Quotient by reciprocal multiplication; the remainder is the low digit.
    always_comb begin
        prod     = {{VALUE_W{1'b0}}, r_mag} * {{VALUE_W{1'b0}}, C_RECIP_10};
        quot     = prod[RECIP_SHIFT +: QUOT_W];
        quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
        rem_full = r_mag - quot_x10;
        rem      = rem_full[DIGIT_W-1:0];
    end

    always_comb begin
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_count = r_count;
        if (i_cmd.load) begin
            n_neg   = i_value[VALUE_W-1];
            n_mag   = i_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(i_value))
                                         : VALUE_W'(i_value);
            n_count = '0;
        end else if (i_cmd.step) begin
            n_mag   = {{(VALUE_W-QUOT_W){1'b0}}, quot};
            n_count = r_count + COUNT_W'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_neg <= n_neg;
    end

    // Digits are pushed least significant first, so the top of the stack
    // always holds the next digit to send.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_stack[0] <= rem;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    always_comb begin
        o_sts.quot_zero  = (quot == '0);
        o_sts.neg        = r_neg;
        o_sts.last_digit = (r_count == COUNT_W'(1));
        o_ch             = i_cmd.sel_sign ? C_ASCII_MINUS
                                          : (C_ASCII_ZERO + CH_W'(r_stack[0]));
        o_last           = !i_cmd.sel_sign && o_sts.last_digit;
    end

endmodule

[src/sbda_controller.sv]
// ----------------------------------------------------------------------------
// sbda_controller
// Sequences loading, digit extraction and character transfers.
// ----------------------------------------------------------------------------
module sbda_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  sbda_pkg::t_sts i_sts,
    output sbda_pkg::t_cmd o_cmd
);
    import sbda_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.quot_zero) begin
                    n_state = i_sts.neg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                if (i_out_ready) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_out_ready && i_sts.last_digit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.pop      = 1'b0;
        o_cmd.sel_sign = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
            end
            S_SIGN: begin
                o_out_valid    = 1'b1;
                o_cmd.sel_sign = 1'b1;
            end
            S_DIGIT: begin
                o_out_valid = 1'b1;
                o_cmd.pop   = i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

[src/signed_binary_to_decimal_ascii_unit.sv]
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_unit
// Converts a signed 32-bit integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// The input channel (i_in_valid, o_in_ready, i_value) takes one two's-
// complement integer per transfer. The output channel (o_out_valid,
// i_out_ready, o_ch, o_last) sends the text one character per transfer,
// most significant first, with a leading '-' for negative values and
// o_last set on the final digit. Zero gives the single character '0', and
// the most negative value gives the full eleven-character text.
// One item is handled at a time. After the input transfer, the datapath
// extracts one digit per cycle with a reciprocal multiply by one tenth.
// Characters then leave one per cycle while the receiver is ready; the
// serial divide step and the one-character output port set the pace.
// If the receiver stalls, the current character and o_last hold steady
// until it is taken. Reset returns the controller to idle; no input is
// accepted until the last character of the current item is transferred.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [sbda_pkg::VALUE_W-1:0] i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [sbda_pkg::CH_W-1:0]           o_ch,
    output logic                                o_last
);
    import sbda_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The controller owns both handshakes and issues one command per cycle.
    sbda_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the magnitude, the sign and the digit stack; the
    // output character is derived from registered state only.
    sbda_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_value (i_value),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_ch    (o_ch),
        .o_last  (o_last)
    );

endmodule

[bench/tb_signed_binary_to_decimal_ascii_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_binary_to_decimal_ascii_unit
// Self-checking bench for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
// Integers are pushed through the input channel from a queue of pending
// values. Every value taken by the unit is spelled out here into the
// characters it should produce, and each character transfer on the output
// channel is checked against the oldest one still owed. A directed set of
// corner values runs first, then random values of every length and sign
// under several mixes of sender idling and receiver back-pressure. The
// bench waits for all owed characters between phases.
// ----------------------------------------------------------------------------
module tb_signed_binary_to_decimal_ascii_unit;

    import sbda_pkg::*;

    localparam int          RADIX         = 10;
    localparam int          MAX_REPORTS   = 10;
    localparam int          PHASE_ITEMS   = 25;
    localparam int          SETTLE_CYCLES = 30;
    localparam int unsigned TIMEOUT_NS    = 2_000_000;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } t_ascii_char;

    localparam int N_CORNERS = 20;
    localparam logic [VALUE_W-1:0] CORNER_VALUES [N_CORNERS] = '{
        32'd0,          32'd1,          32'hFFFF_FFFF,  32'd9,
        32'd10,         -32'sd10,       32'h7FFF_FFFF,  32'h8000_0000,
        32'h8000_0001,  32'h7FFF_FFFE,  32'd1000000000, -32'sd1000000000,
        32'd999999999,  -32'sd9,        32'd100,        32'd1234567890,
        -32'sd123456789, 32'h5555_5555, 32'hAAAA_AAAA,  32'd4096
    };

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic signed [VALUE_W-1:0] i_value     = '0;
    logic                      i_out_ready = 1'b0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic [CH_W-1:0]           o_ch;
    logic                      o_last;

    // Idling mix of the current phase, in percent of cycles.
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;

    logic [VALUE_W-1:0] pending_values [$];
    t_ascii_char        owed_chars     [$];
    logic               value_taken = 1'b0;

    int values_queued   = 0;
    int values_taken    = 0;
    int negatives_taken = 0;
    int chars_checked   = 0;
    int mismatch_count  = 0;

    signed_binary_to_decimal_ascii_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ch        (o_ch),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Spells a 32-bit two's-complement value into the characters it owes.
    // The magnitude is taken as an unsigned quantity, so the most negative
    // value needs no special handling.
    function automatic void spell_decimal(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] mag;
        logic [DIGIT_W-1:0] digits [MAX_DIGITS];
        int                 nd;
        t_ascii_char        c;
        nd  = 0;
        mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
        do begin
            digits[nd] = DIGIT_W'(mag % RADIX);
            nd++;
            mag = mag / RADIX;
        end while (mag != 0 && nd < MAX_DIGITS);
        if (raw[VALUE_W-1]) begin
            c.ch   = C_ASCII_MINUS;
            c.last = 1'b0;
            owed_chars.push_back(c);
        end
        for (int k = nd - 1; k >= 0; k--) begin
            c.ch   = C_ASCII_ZERO + CH_W'(digits[k]);
            c.last = (k == 0);
            owed_chars.push_back(c);
        end
    endfunction

    // Random value: a quarter are raw 32-bit patterns, the rest have a
    // random number of digits so that short and long texts are both common.
    function automatic logic [VALUE_W-1:0] pick_value();
        longint unsigned span;
        longint unsigned mag;
        int unsigned     ndig;
        if ($urandom_range(0, 3) == 0) begin
            return $urandom;
        end
        ndig = $urandom_range(1, MAX_DIGITS);
        span = 1;
        repeat (ndig) span *= RADIX;
        mag = {$urandom, $urandom} % span;
        if ($urandom_range(0, 1) == 1) begin
            if (mag > 64'd2147483648) mag = 64'd2147483648;
            return VALUE_W'(64'd0 - mag);
        end
        if (mag > 64'd2147483647) mag = 64'd2147483647;
        return VALUE_W'(mag);
    endfunction

    task automatic queue_value(input logic [VALUE_W-1:0] v);
        pending_values.push_back(v);
        values_queued++;
    endtask

    // Holds the sender back until every queued value has been taken and
    // every character it owes has been transferred.
    task automatic wait_drained();
        while (values_taken != values_queued || owed_chars.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (PHASE_ITEMS) queue_value(pick_value());
        wait_drained();
    endtask

    // Sampling side: records input transfers into the prediction and checks
    // each output transfer against the oldest owed character.
    always @(posedge i_clk) begin : monitor
        t_ascii_char want;
        if (!i_rst_n) begin
            value_taken <= 1'b0;
        end else begin
            value_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                spell_decimal(i_value);
                values_taken++;
                if (i_value < 0) negatives_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                if (owed_chars.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: character 0x%02h last=%0b with nothing owed",
                                 $realtime, o_ch, o_last);
                    end
                end else begin
                    want = owed_chars.pop_front();
                    chars_checked++;
                    if (o_ch !== want.ch || o_last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("%0t: expected ch=0x%02h last=%0b, got ch=0x%02h last=%0b",
                                     $realtime, want.ch, want.last, o_ch, o_last);
                        end
                    end
                end
            end
        end
    end

    // Driving side: inputs move on the falling edge. A presented value
    // stays put until the rising edge that transfers it.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || value_taken) begin
            if (pending_values.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                i_value    <= pending_values.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Corner values first, with both sides running flat out.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        foreach (CORNER_VALUES[i]) queue_value(CORNER_VALUES[i]);
        wait_drained();

        run_random_phase(0, 0);
        run_random_phase(59, 0);
        run_random_phase(0, 59);
        run_random_phase(18, 18);

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Converted %0d integers (%0d negative, %0d corner values) into %0d characters.",
                 values_taken, negatives_taken, N_CORNERS, chars_checked);
        $display("Phases covered free flow, sender gaps, receiver stalls and both; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0 && owed_chars.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d characters still owed.", owed_chars.size());
        $display("FAILURE");
        $finish;
    end

endmodule
